FILE: rtl/deq_pkg.sv
package deq_pkg;

   // request codes; codes 5 to 7 behave as a query
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_QUERY      = 3'd4;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   localparam int VALUE_W = 32;
   localparam int COUNT_OUT_W = 5;

   localparam logic [VALUE_W-1:0] EMPTY_READ = '1;

   typedef struct packed {
      logic update;   // apply the accepted request to pointers and slots
      logic load;     // capture the result into the output register
   } deq_cmd_type;

endpackage

FILE: rtl/deq_ram.sv
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: rtl/deq_ctrl.sv
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output deq_pkg::deq_cmd_type cmd
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;
   logic       load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   // output register is free when empty or its transfer completes now
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == ST_LOAD) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign cmd       = deq_cmd_type'{update: accept, load: load};

endmodule

FILE: rtl/deq_dpath.sv
module deq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  deq_pkg::deq_cmd_type                   cmd,
   input  logic [2:0]                             req_type,
   input  logic signed [deq_pkg::VALUE_W-1:0]     req_push_value,
   output logic signed [deq_pkg::VALUE_W-1:0]     rsp_front_value,
   output logic signed [deq_pkg::VALUE_W-1:0]     rsp_back_value,
   output logic [deq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output logic                                   rsp_is_empty,
   output logic [1:0]                             rsp_status
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // ring position of pos + off, pos below DEPTH and off at most DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      begin
         sum = SUM_W'(pos) + SUM_W'(off);
         if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
         end
         ring_add = sum[IDX_W-1:0];
      end
   endfunction

   logic [IDX_W-1:0]   head_ff;
   logic [IDX_W-1:0]   head_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [1:0]         status_ff;
   logic [1:0]         status_in;

   logic               is_full;
   logic               is_none;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   head_prev;
   logic [IDX_W-1:0]   back_addr;
   logic [VALUE_W-1:0] front_data;
   logic [VALUE_W-1:0] back_data;

   logic signed [VALUE_W-1:0]  front_ff;
   logic signed [VALUE_W-1:0]  back_ff;
   logic [COUNT_OUT_W-1:0]     entry_count_ff;
   logic                       empty_ff;
   logic [1:0]                 rsp_status_ff;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_none   = (count_ff == '0);
   assign head_prev = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = ring_add(head_ff, count_ff);
      case (req_type)
         REQ_PUSH_FRONT: begin
            if (is_full) begin
               status_in = STATUS_PUSH_FULL;
            end else begin
               head_in  = head_prev;
               count_in = count_ff + 1'b1;
               wr_en    = 1'b1;
               wr_addr  = head_prev;
            end
         end
         REQ_PUSH_BACK: begin
            if (is_full) begin
               status_in = STATUS_PUSH_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               wr_en    = 1'b1;
            end
         end
         REQ_POP_FRONT: begin
            if (is_none) begin
               status_in = STATUS_POP_EMPTY;
            end else begin
               head_in  = ring_add(head_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
            end
         end
         REQ_POP_BACK: begin
            if (is_none) begin
               status_in = STATUS_POP_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         status_ff <= status_in;
      end
   end

   // back slot address; don't care when empty
   assign back_addr = is_none ? head_ff : ring_add(head_ff, count_ff - 1'b1);

   deq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (cmd.update && wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_push_value),
      .rd_addr_a (head_ff),
      .rd_addr_b (back_addr),
      .rd_data_a (front_data),
      .rd_data_b (back_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         front_ff       <= is_none ? EMPTY_READ : front_data;
         back_ff        <= is_none ? EMPTY_READ : back_data;
         entry_count_ff <= COUNT_OUT_W'(count_ff);
         empty_ff       <= is_none;
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_front_value = front_ff;
   assign rsp_back_value  = back_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

FILE: rtl/double_ended_queue.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_type, req_push_value
// rsp       out        rsp_valid/rsp_stall   rsp_front_value, rsp_back_value,
//                                            rsp_entry_count, rsp_is_empty, rsp_status
//
// One request at a time: the transfer edge updates the ring pointers and writes
// the slot, the next edge reads front and back from the slot RAM (registered read
// port), and a later edge loads the result register once it is free.
// A new request is taken while the previous result still waits in that register.
// A held rsp_stall delays the load and so holds off further requests.
// Synchronous reset empties the queue; slot contents are left as they are.
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_type,
   input  logic signed [deq_pkg::VALUE_W-1:0]  req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [deq_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [deq_pkg::VALUE_W-1:0]  rsp_back_value,
   output logic [deq_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic [1:0]                          rsp_status
);
   import deq_pkg::*;

   deq_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

endmodule

FILE: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT = 2000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
      logic [COUNT_OUT_W-1:0]    entry_count;
      logic                      is_empty;
      logic [1:0]                status;
   } deq_snapshot_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [2:0]                 req_type;
   logic signed [VALUE_W-1:0]  req_push_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [VALUE_W-1:0]  rsp_front_value;
   logic signed [VALUE_W-1:0]  rsp_back_value;
   logic [COUNT_OUT_W-1:0]     rsp_entry_count;
   logic                       rsp_is_empty;
   logic [1:0]                 rsp_status;

   // shadow copy of the deque
   logic signed [VALUE_W-1:0]  ring_copy [QUEUE_DEPTH];
   logic [3:0]                 ring_head;
   logic [4:0]                 ring_count;

   deq_snapshot_type pending_snapshots [$];
   int            errors;
   bit            req_gaps;
   bit            rsp_gaps;
   bit            long_hold;

   double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

   // apply one request to the shadow deque and return what the block should report
   function automatic deq_snapshot_type apply_request(input logic [2:0] kind,
                                                      input logic signed [VALUE_W-1:0] value);
      deq_snapshot_type snap;
      snap.status = STATUS_DONE;
      case (kind)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (ring_count >= QUEUE_DEPTH) begin
               snap.status = STATUS_PUSH_FULL;
            end else if (kind == REQ_PUSH_FRONT) begin
               ring_head = ring_head - 4'd1;
               ring_copy[ring_head] = value;
               ring_count = ring_count + 5'd1;
            end else begin
               ring_copy[ring_head + ring_count[3:0]] = value;
               ring_count = ring_count + 5'd1;
            end
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (ring_count == 0) begin
               snap.status = STATUS_POP_EMPTY;
            end else begin
               if (kind == REQ_POP_FRONT)
                  ring_head = ring_head + 4'd1;
               ring_count = ring_count - 5'd1;
            end
         end
         default: ;  // query and unused codes
      endcase
      if (ring_count == 0) begin
         snap.front_value = EMPTY_READ;
         snap.back_value  = EMPTY_READ;
      end else begin
         snap.front_value = ring_copy[ring_head];
         // count[3:0] is 0 when full, which still lands on head - 1
         snap.back_value  = ring_copy[ring_head + ring_count[3:0] - 4'd1];
      end
      snap.entry_count = ring_count;
      snap.is_empty    = (ring_count == 0);
      return snap;
   endfunction

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : track_transfers
      deq_snapshot_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_snapshots.push_back(apply_request(req_type, req_push_value));
         if (rsp_valid && !rsp_stall) begin
            if (pending_snapshots.size() == 0) begin
               $display("%0t: result transfer with no request outstanding", $time);
               errors++;
            end else begin
               want = pending_snapshots.pop_front();
               compare_field("front_value", want.front_value, rsp_front_value);
               compare_field("back_value", want.back_value, rsp_back_value);
               compare_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               compare_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
               compare_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
      end
   end

   // result side: random stall bursts, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // returns at the edge where the transfer happened; valid is left high
   task automatic send_request(input logic [2:0] kind, input logic signed [VALUE_W-1:0] value);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      int n;
      req_valid <= 1'b0;
      @(posedge clock);
      for (n = 0; n < DRAIN_LIMIT && pending_snapshots.size() != 0; n++)
         @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sh0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // push_bias in percent steers the fill level
   function automatic logic [2:0] random_kind(input int push_bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_bias)
         return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else if (r < 92)
         return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      else if (r < 97)
         return REQ_QUERY;
      else
         return 3'($urandom_range(5, 7));
   endfunction

   task automatic test_directed();
      send_request(REQ_QUERY, 32'sd0);
      send_request(REQ_POP_FRONT, 32'sd0);
      send_request(REQ_POP_BACK, 32'sd0);
      send_request(3'd5, $urandom);
      send_request(3'd6, $urandom);
      send_request(3'd7, $urandom);
      send_request(REQ_PUSH_BACK, 32'sh7fff_ffff);
      send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
      send_request(REQ_QUERY, 32'sd0);
      send_request(REQ_POP_BACK, 32'sd0);
      send_request(REQ_POP_FRONT, 32'sd0);
      send_request(REQ_POP_FRONT, 32'sd0);
      send_request(REQ_PUSH_FRONT, -32'sd1);
      send_request(REQ_PUSH_BACK, 32'sd0);
      send_request(REQ_PUSH_BACK, 32'sh5555_5555);
      send_request(REQ_PUSH_FRONT, 32'shaaaa_aaaa);
      send_request(REQ_POP_BACK, 32'sd0);
      send_request(REQ_POP_FRONT, 32'sd0);
      send_request(REQ_POP_BACK, 32'sd0);
      send_request(REQ_POP_FRONT, 32'sd0);
      drain_results();
   endtask

   task automatic test_full_queue();
      int i;
      for (i = 0; i < QUEUE_DEPTH; i++)
         send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, random_value());
      send_request(REQ_PUSH_FRONT, random_value());
      send_request(REQ_PUSH_BACK, random_value());
      send_request(REQ_QUERY, random_value());
      for (i = 0; i <= QUEUE_DEPTH; i++)
         send_request(i[0] ? REQ_POP_BACK : REQ_POP_FRONT, random_value());
      drain_results();
   endtask

   task automatic test_back_pressure();
      int i;
      long_hold = 1'b1;
      for (i = 0; i < 24; i++)
         send_request(random_kind(60), random_value());
      drain_results();
   endtask

   task automatic test_random_mix();
      int i;
      int push_bias;
      for (i = 0; i < 440; i++) begin
         case ((i / 40) % 3)
            0:       push_bias = 75;
            1:       push_bias = 25;
            default: push_bias = 50;
         endcase
         send_request(random_kind(push_bias), random_value());
      end
      drain_results();
   endtask

   task automatic test_full_rate();
      int i;
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      for (i = 0; i < 60; i++)
         send_request(random_kind(55), random_value());
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_QUERY;
      req_push_value = '0;
      ring_head      = '0;
      ring_count     = '0;
      errors         = 0;
      req_gaps       = 1'b1;
      rsp_gaps       = 1'b1;
      long_hold      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_queue();
      test_back_pressure();
      test_random_mix();
      test_full_rate();

      repeat (8) @(posedge clock);
      if (pending_snapshots.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_snapshots.size());
         errors++;
      end
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
